/* hdl/mwaf_pkg.sv */
// Shared types and register constants for the moving average weight filter.
package mwaf_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_LOAD,
      ST_DIVIDE,
      ST_SIGN,
      ST_DIFF,
      ST_MULT,
      ST_SAT,
      ST_DONE
   } state_type;

   localparam int CSR_ADDR_W = 4;

   typedef enum logic [1:0] {
      REG_WINDOW = 2'd0,
      REG_TARE   = 2'd1,
      REG_SCALE  = 2'd2,
      REG_NONE   = 2'd3
   } reg_index_type;

   localparam logic [31:0] SCALE_RESET = 32'h0001_0000;
   localparam logic [47:0] W48_MAX     = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] W48_MIN     = 48'h8000_0000_0000;

endpackage

/* hdl/mwaf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module mwaf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/moving_average_weight_filter.sv */
// Boxcar moving average of load-cell sums with fill-up, tare offset and Q16.16 scaling.
// Each request carries one cleaned load-cell sum and two validity flags and yields exactly
// one response. A valid request enters a ring of the last window_length samples held in a
// RAM; until the ring is full the average runs over the samples seen so far, truncated
// toward zero, and the weight is (average - tare_offset) * scale_factor saturated to signed
// 48 bits. An invalid request repeats the last response. A valid request passes through a
// restoring divider that retires one quotient bit per cycle; an invalid request skips it.
// The block takes one request at a time. Writing window_length clears the filter state at
// once; the ring needs no clearing pass since only entries written since the last clear
// are ever read.
module moving_average_weight_filter #(
   parameter int MAX_WINDOW = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [31:0]                     req_tdata,   // [31:0] clean_value
   input  logic [1:0]                      req_tuser,   // [0] sample_ok, [1] clean_ok
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [79:0]                     rsp_tdata,   // [31:0] average_sum, [79:32] weight_total
   output logic [0:0]                      rsp_tuser,   // [0] result_ok
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mwaf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   import mwaf_pkg::*;

   localparam int ADDR_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CNT_W     = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W     = 32 + $clog2(MAX_WINDOW);
   localparam int STEP_W    = $clog2(SUM_W);
   localparam int WIN_RESET = (MAX_WINDOW < 8) ? MAX_WINDOW : 8;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]        window_ff, window_in;
   logic signed [31:0]      tare_ff, tare_in;
   logic signed [31:0]      scale_ff, scale_in;

   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic [ADDR_W-1:0]       slot_ff, slot_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [31:0]      held_avg_ff, held_avg_in;
   logic [47:0]             held_total_ff, held_total_in;
   logic                    held_ok_ff, held_ok_in;

   logic signed [31:0]      x_ff, x_in;
   logic [SUM_W-1:0]        quo_ff, quo_in;
   logic [CNT_W-1:0]        rem_ff, rem_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    neg_ff, neg_in;
   logic signed [31:0]      avg_ff, avg_in;
   logic signed [32:0]      diff_ff, diff_in;
   logic signed [64:0]      prod_ff, prod_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [31:0]             rsp_avg_ff, rsp_avg_in;
   logic [47:0]             rsp_total_ff, rsp_total_in;
   logic                    rsp_ok_ff, rsp_ok_in;

   logic                    req_accept;
   logic                    req_ok;
   logic                    csr_write;
   reg_index_type           csr_index;
   logic                    out_load;
   logic                    ring_full;
   logic [CNT_W-1:0]        slot_next;
   logic [CNT_W:0]          trial;
   logic                    trial_ge;
   logic [CNT_W:0]          trial_sub;
   logic [31:0]             ram_rdata;
   logic [SUM_W-1:0]        sum_mag;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_ok     = req_tuser[0] && req_tuser[1];
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);
   assign out_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   assign ring_full  = (fill_ff >= window_ff);
   assign slot_next  = CNT_W'(slot_ff) + CNT_W'(1);
   assign trial      = {rem_ff, quo_ff[SUM_W-1]};
   assign trial_ge   = (trial >= {1'b0, fill_ff});
   assign trial_sub  = trial - {1'b0, fill_ff};
   assign sum_mag    = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_total_ff, rsp_avg_ff};
   assign rsp_tuser  = rsp_ok_ff;

   always_comb begin
      case (csr_index)
         REG_WINDOW: csr_prdata = 32'(window_ff);
         REG_TARE:   csr_prdata = tare_ff;
         REG_SCALE:  csr_prdata = scale_ff;
         default:    csr_prdata = 32'd0;
      endcase
   end

   mwaf_ram #(
      .WIDTH (32),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (state_ff == ST_UPDATE),
      .wr_addr (slot_ff),
      .wr_data (x_ff),
      .rd_en   (req_accept),
      .rd_addr (slot_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = req_ok ? ST_UPDATE : ST_DONE;
            end
         end
         ST_UPDATE: state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN:   state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_MULT;
         ST_MULT:   state_in = ST_SAT;
         ST_SAT:    state_in = ST_DONE;
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      window_in     = window_ff;
      tare_in       = tare_ff;
      scale_in      = scale_ff;
      fill_in       = fill_ff;
      slot_in       = slot_ff;
      sum_in        = sum_ff;
      held_avg_in   = held_avg_ff;
      held_total_in = held_total_ff;
      held_ok_in    = held_ok_ff;
      x_in          = x_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      neg_in        = neg_ff;
      avg_in        = avg_ff;
      diff_in       = diff_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_avg_in    = rsp_avg_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_ok_in     = rsp_ok_ff;

      if (req_accept) begin
         x_in = signed'(req_tdata);
      end

      case (state_ff)
         ST_UPDATE: begin
            if (ring_full) begin
               sum_in = sum_ff + SUM_W'(x_ff) - SUM_W'(signed'(ram_rdata));
            end else begin
               sum_in  = sum_ff + SUM_W'(x_ff);
               fill_in = fill_ff + CNT_W'(1);
            end
            slot_in = (slot_next >= window_ff) ? ADDR_W'(0) : ADDR_W'(slot_next);
         end
         ST_LOAD: begin
            neg_in  = sum_ff[SUM_W-1];
            quo_in  = sum_mag;
            rem_in  = '0;
            step_in = '0;
         end
         ST_DIVIDE: begin
            rem_in  = trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_in  = {quo_ff[SUM_W-2:0], trial_ge};
            step_in = step_ff + STEP_W'(1);
         end
         ST_SIGN: begin
            avg_in = neg_ff ? -signed'(quo_ff[31:0]) : signed'(quo_ff[31:0]);
         end
         ST_DIFF: begin
            diff_in = 33'(avg_ff) - 33'(tare_ff);
         end
         ST_MULT: begin
            prod_in = 65'(diff_ff) * 65'(scale_ff);
         end
         ST_SAT: begin
            if ((&prod_ff[64:47]) || !(|prod_ff[64:47])) begin
               held_total_in = prod_ff[47:0];
            end else begin
               held_total_in = prod_ff[64] ? W48_MIN : W48_MAX;
            end
            held_avg_in = avg_ff;
            held_ok_in  = 1'b1;
         end
         default: begin
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_avg_in   = held_avg_ff;
         rsp_total_in = held_total_ff;
         rsp_ok_in    = held_ok_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write) begin
         case (csr_index)
            REG_WINDOW: begin
               if (csr_pwdata[5:0] == 6'd0) begin
                  window_in = CNT_W'(1);
               end else if (int'(csr_pwdata[5:0]) > MAX_WINDOW) begin
                  window_in = CNT_W'(MAX_WINDOW);
               end else begin
                  window_in = CNT_W'(csr_pwdata[5:0]);
               end
               fill_in       = '0;
               slot_in       = '0;
               sum_in        = '0;
               held_avg_in   = '0;
               held_total_in = '0;
               held_ok_in    = 1'b0;
            end
            REG_TARE:  tare_in  = signed'(csr_pwdata);
            REG_SCALE: scale_in = signed'(csr_pwdata);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         window_ff     <= CNT_W'(WIN_RESET);
         tare_ff       <= '0;
         scale_ff      <= signed'(SCALE_RESET);
         fill_ff       <= '0;
         slot_ff       <= '0;
         sum_ff        <= '0;
         held_avg_ff   <= '0;
         held_total_ff <= '0;
         held_ok_ff    <= 1'b0;
         step_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         window_ff     <= window_in;
         tare_ff       <= tare_in;
         scale_ff      <= scale_in;
         fill_ff       <= fill_in;
         slot_ff       <= slot_in;
         sum_ff        <= sum_in;
         held_avg_ff   <= held_avg_in;
         held_total_ff <= held_total_in;
         held_ok_ff    <= held_ok_in;
         step_ff       <= step_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      neg_ff       <= neg_in;
      avg_ff       <= avg_in;
      diff_ff      <= diff_in;
      prod_ff      <= prod_in;
      rsp_avg_ff   <= rsp_avg_in;
      rsp_total_ff <= rsp_total_in;
      rsp_ok_ff    <= rsp_ok_in;
   end

`ifndef SYNTHESIS
   a_fill_in_window: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= window_ff)
      else $error("Fill count exceeds the window length.");

   a_slot_in_window: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(slot_ff) < window_ff)
      else $error("Write slot lies outside the window.");

   a_empty_sum_zero: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> (sum_ff == '0))
      else $error("Running sum is nonzero with an empty ring.");

   a_held_zero: assert property (@(posedge clock) disable iff (reset)
      !held_ok_ff |-> (held_avg_ff == '0 && held_total_ff == '0))
      else $error("Held result is nonzero before any valid request.");

   a_divider_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && step_ff == STEP_W'(SUM_W - 1)) |=> (state_ff == ST_SIGN))
      else $error("Divider did not finish after its last step.");
`endif

endmodule
